FILE: src/sgr_pkg.sv
// ----------------------------------------------------------------------------
// sgr_pkg
// Shared types and constants for the stream group reverser: the shift
// operation code that drives every cell of the storage chain, and the group size width.
// ----------------------------------------------------------------------------
package sgr_pkg;

    // shift operation shared by every cell of the chain
    typedef logic [1:0] t_shift_op;

    localparam t_shift_op OP_HOLD = 2'd0;  // every cell keeps its data
    localparam t_shift_op OP_UP   = 2'd1;  // cell i takes cell i-1, cell 0 takes input
    localparam t_shift_op OP_DOWN = 2'd2;  // cell i takes cell i+1

    // width of the group size register
    localparam int GROUP_SIZE_W = 5;

endpackage

FILE: src/sgr_cell.sv
// ----------------------------------------------------------------------------
// sgr_cell
// One storage cell of the reversal chain. Holds one element and takes the
// element of its lower or upper neighbor when the chain shifts.
// ----------------------------------------------------------------------------
module sgr_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  sgr_pkg::t_shift_op    i_op,
    input  logic [DATA_WIDTH-1:0] i_from_below,
    input  logic [DATA_WIDTH-1:0] i_from_above,
    output logic [DATA_WIDTH-1:0] o_data
);
    import sgr_pkg::*;

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    // neighbor select
    always_comb begin
        case (i_op)
            OP_UP:   n_data = i_from_below;
            OP_DOWN: n_data = i_from_above;
            OP_HOLD: n_data = r_data;
            default: n_data = r_data;
        endcase
    end

    // payload register, no reset
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

FILE: src/stream_group_reverser.sv
// Output: the first element of a complete group goes straight to the output
// register if it is free; otherwise, as for a partial group, it is pushed
// into the chain first. Input: one element per cycle while collecting; the
// input is not ready while a group drains from the chain.
// Reset: synchronous active low; clears fill count, remaining count, state,
// output valid and sets group size to 1. Cell contents stay undefined until written.
// ----------------------------------------------------------------------------
// stream_group_reverser
// Reverses a stream of list elements in groups of a configured size. A
// partial group at the end of the list leaves in its original order. The
// elements sit in a chain of shift cells: newest at cell 0.
// ----------------------------------------------------------------------------
module stream_group_reverser #(
    parameter int MAX_GROUP  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [sgr_pkg::GROUP_SIZE_W-1:0]    i_cfg_data,
    // input channel
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [DATA_WIDTH-1:0]        i_value,
    input  logic                                i_is_final,
    // output channel
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [DATA_WIDTH-1:0]        o_out_value,
    output logic                                o_run_end,
    output logic                                o_list_end
);
    import sgr_pkg::*;

    localparam int CW = $clog2(MAX_GROUP + 1);
    localparam int IW = $clog2(MAX_GROUP);
    localparam int EW = ((CW > GROUP_SIZE_W) ? CW : GROUP_SIZE_W) + 1;

    localparam logic S_COLLECT = 1'b0;
    localparam logic S_DRAIN   = 1'b1;

    // control registers
    logic                    r_state,      n_state;
    logic [CW-1:0]           r_fill,       n_fill;
    logic [CW-1:0]           r_left,       n_left;
    logic                    r_rev,        n_rev;
    logic                    r_fin,        n_fin;
    logic [IW-1:0]           r_idx,        n_idx;
    logic [GROUP_SIZE_W-1:0] r_group_size;
    logic                    r_out_valid,  n_out_valid;
    logic [DATA_WIDTH-1:0]   r_out_value,  n_out_value;
    logic                    r_run_end,    n_run_end;
    logic                    r_list_end,   n_list_end;

    logic                    w_accept;
    logic                    w_out_free;
    logic [EW-1:0]           w_group_eff;
    logic [EW-1:0]           w_fill_next;
    logic                    w_complete;
    t_shift_op               w_op;
    logic [DATA_WIDTH-1:0]   w_cell [MAX_GROUP];
    logic [DATA_WIDTH-1:0]   w_drain_data;

    assign o_ready    = (r_state == S_COLLECT);
    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;

    // effective group size: zero counts as one, saturate at the chain length
    always_comb begin
        w_group_eff = EW'(r_group_size);
        if (r_group_size == '0) begin
            w_group_eff = EW'(1);
        end else if (EW'(r_group_size) > EW'(MAX_GROUP)) begin
            w_group_eff = EW'(MAX_GROUP);
        end
    end

    assign w_fill_next = EW'(r_fill) + EW'(1);
    assign w_complete  = (w_fill_next >= w_group_eff);

    // cell chain
    for (genvar gi = 0; gi < MAX_GROUP; gi++) begin : g_chain
        logic [DATA_WIDTH-1:0] w_below;
        logic [DATA_WIDTH-1:0] w_above;
        if (gi == 0) begin : g_head
            assign w_below = i_value;
        end else begin : g_body
            assign w_below = w_cell[gi-1];
        end
        if (gi == MAX_GROUP - 1) begin : g_top
            assign w_above = w_cell[gi];
        end else begin : g_mid
            assign w_above = w_cell[gi+1];
        end
        sgr_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_op         (w_op),
            .i_from_below (w_below),
            .i_from_above (w_above),
            .o_data       (w_cell[gi])
        );
    end

    // reversed drain pops the head, in-order drain reads the oldest slot
    assign w_drain_data = r_rev ? w_cell[0] : w_cell[r_idx];

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_left      = r_left;
        n_rev       = r_rev;
        n_fin       = r_fin;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_ready;
        n_out_value = r_out_value;
        n_run_end   = r_run_end;
        n_list_end  = r_list_end;
        w_op        = OP_HOLD;

        case (r_state)
            S_COLLECT: begin
                if (w_accept) begin
                    if (w_complete && w_out_free) begin
                        // newest element leaves at once, the rest pop from the head
                        n_out_valid = 1'b1;
                        n_out_value = i_value;
                        n_run_end   = (r_fill == '0);
                        n_list_end  = (r_fill == '0) && i_is_final;
                        n_rev       = 1'b1;
                        n_fin       = i_is_final;
                        n_left      = r_fill;
                        n_fill      = '0;
                        if (r_fill != '0) begin
                            n_state = S_DRAIN;
                        end
                    end else if (w_complete) begin
                        // output register busy: push and drain reversed
                        w_op    = OP_UP;
                        n_rev   = 1'b1;
                        n_fin   = i_is_final;
                        n_left  = CW'(w_fill_next);
                        n_fill  = '0;
                        n_state = S_DRAIN;
                    end else if (i_is_final) begin
                        // partial group, drain oldest first
                        w_op    = OP_UP;
                        n_rev   = 1'b0;
                        n_fin   = 1'b1;
                        n_idx   = r_fill[IW-1:0];
                        n_left  = CW'(w_fill_next);
                        n_fill  = '0;
                        n_state = S_DRAIN;
                    end else begin
                        w_op   = OP_UP;
                        n_fill = CW'(w_fill_next);
                    end
                end
            end
            S_DRAIN: begin
                if (w_out_free) begin
                    w_op        = r_rev ? OP_DOWN : OP_UP;
                    n_out_valid = 1'b1;
                    n_out_value = w_drain_data;
                    n_run_end   = (r_left == CW'(1));
                    n_list_end  = (r_left == CW'(1)) && r_fin;
                    n_left      = r_left - CW'(1);
                    if (r_left == CW'(1)) begin
                        n_state = S_COLLECT;
                    end
                end
            end
            default: begin
                n_state = S_COLLECT;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_COLLECT;
            r_fill       <= '0;
            r_left       <= '0;
            r_out_valid  <= 1'b0;
            r_group_size <= GROUP_SIZE_W'(1);
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_group_size <= i_cfg_data;
            end
        end
    end

    // payload and drain mode registers
    always_ff @(posedge i_clk) begin
        r_rev       <= n_rev;
        r_fin       <= n_fin;
        r_idx       <= n_idx;
        r_out_value <= n_out_value;
        r_run_end   <= n_run_end;
        r_list_end  <= n_list_end;
    end

    assign o_valid     = r_out_valid;
    assign o_out_value = r_out_value;
    assign o_run_end   = r_run_end;
    assign o_list_end  = r_list_end;

endmodule
